[hdl/timed_blind_position_controller_core_macros.svh]
// assertion macros used by the blind controller core
`ifndef TIMED_BLIND_POSITION_CONTROLLER_CORE_MACROS_SVH
`define TIMED_BLIND_POSITION_CONTROLLER_CORE_MACROS_SVH

// checked only outside reset
`define TBPC_ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define TBPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/tbpc_pkg.sv]
// types, codes and constants of the timed blind position controller
package tbpc_pkg;

    localparam logic [7:0] MAX_POS = 8'd100;

    localparam logic [1:0] OP_CONTROL = 2'd0;
    localparam logic [1:0] OP_SET_POS = 2'd1;
    localparam logic [1:0] OP_STOP    = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    localparam logic [1:0] CFG_STEP_TIME    = 2'd0;
    localparam logic [1:0] CFG_OPEN_ENABLE  = 2'd1;
    localparam logic [1:0] CFG_CLOSE_ENABLE = 2'd2;
    localparam logic [1:0] CFG_SWAP_BUTTONS = 2'd3;

    localparam logic [15:0] STEP_TIME_RESET = 16'd1000;

    typedef enum logic [1:0] {
        MOT_STOPPED = 2'd0,
        MOT_OPENING = 2'd1,
        MOT_CLOSING = 2'd2
    } motion_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [7:0]  target_value;
        logic        open_pressed;
        logic        close_pressed;
    } item_t;

    typedef struct packed {
        logic       relay_open;
        logic       relay_close;
        logic [1:0] motion;
        logic [7:0] position;
        logic       position_changed;
    } result_t;

    typedef struct packed {
        logic [15:0] step_time_ms;
        logic        open_button_enable;
        logic        close_button_enable;
        logic        swap_buttons;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  current_position;
        logic [7:0]  target_position;
        motion_t     motion_state;
        logic [31:0] last_step_time;
    } state_t;

    localparam state_t STATE_RESET = '{
        current_position: 8'd0,
        target_position:  8'd0,
        motion_state:     MOT_STOPPED,
        last_step_time:   32'd0
    };

endpackage

[hdl/tbpc_cfg_regs.sv]
// configuration register file of the blind controller
module tbpc_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output tbpc_pkg::cfg_t     cfg
);

    tbpc_pkg::cfg_t cfg_reg;
    tbpc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                tbpc_pkg::CFG_STEP_TIME:    cfg_next.step_time_ms        = cfg_wdata;
                tbpc_pkg::CFG_OPEN_ENABLE:  cfg_next.open_button_enable  = cfg_wdata[0];
                tbpc_pkg::CFG_CLOSE_ENABLE: cfg_next.close_button_enable = cfg_wdata[0];
                tbpc_pkg::CFG_SWAP_BUTTONS: cfg_next.swap_buttons        = cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_time_ms        <= tbpc_pkg::STEP_TIME_RESET;
            cfg_reg.open_button_enable  <= 1'b1;
            cfg_reg.close_button_enable <= 1'b1;
            cfg_reg.swap_buttons        <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/tbpc_step.sv]
// next-state and result logic for one operation of the blind controller
module tbpc_step (
    input  tbpc_pkg::cfg_t     cfg,
    input  tbpc_pkg::state_t   state_cur,
    input  tbpc_pkg::item_t    item,
    output tbpc_pkg::state_t   state_nxt,
    output tbpc_pkg::result_t  result
);

    logic [7:0]  tv_clamped;
    logic        eff_open;
    logic        eff_close;
    logic [31:0] elapsed;
    logic        changed;
    tbpc_pkg::state_t nxt;

    assign tv_clamped = (item.target_value > tbpc_pkg::MAX_POS) ? tbpc_pkg::MAX_POS
                                                                : item.target_value;
    assign eff_open   = cfg.swap_buttons ? item.close_pressed : item.open_pressed;
    assign eff_close  = cfg.swap_buttons ? item.open_pressed  : item.close_pressed;

    always_comb begin
        nxt     = state_cur;
        changed = 1'b0;
        elapsed = 32'd0;
        unique case (item.operation)
            tbpc_pkg::OP_CONTROL: begin
                // open press is handled before close
                if (cfg.open_button_enable && eff_open) begin
                    if (nxt.motion_state == tbpc_pkg::MOT_STOPPED &&
                        nxt.current_position != tbpc_pkg::MAX_POS) begin
                        nxt.target_position = tbpc_pkg::MAX_POS;
                        nxt.motion_state    = (tbpc_pkg::MAX_POS > nxt.current_position) ?
                                              tbpc_pkg::MOT_OPENING : tbpc_pkg::MOT_CLOSING;
                        nxt.last_step_time  = item.now_ms;
                    end else begin
                        nxt.target_position = nxt.current_position;
                        nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
                    end
                end
                if (cfg.close_button_enable && eff_close) begin
                    if (nxt.motion_state == tbpc_pkg::MOT_STOPPED &&
                        nxt.current_position != 8'd0) begin
                        nxt.target_position = 8'd0;
                        nxt.motion_state    = tbpc_pkg::MOT_CLOSING;
                        nxt.last_step_time  = item.now_ms;
                    end else begin
                        nxt.target_position = nxt.current_position;
                        nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
                    end
                end
                // elapsed time wraps with the time stamp
                elapsed = item.now_ms - nxt.last_step_time;
                if (nxt.motion_state != tbpc_pkg::MOT_STOPPED &&
                    elapsed >= {16'd0, cfg.step_time_ms}) begin
                    nxt.last_step_time = item.now_ms;
                    changed            = 1'b1;
                    if (nxt.motion_state == tbpc_pkg::MOT_OPENING) begin
                        if (nxt.current_position < nxt.target_position) begin
                            nxt.current_position = nxt.current_position + 8'd1;
                        end
                        if (nxt.current_position >= nxt.target_position) begin
                            nxt.target_position = nxt.current_position;
                            nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
                        end
                    end else begin
                        if (nxt.current_position > nxt.target_position) begin
                            nxt.current_position = nxt.current_position - 8'd1;
                        end
                        if (nxt.current_position <= nxt.target_position) begin
                            nxt.target_position = nxt.current_position;
                            nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
                        end
                    end
                end
            end
            tbpc_pkg::OP_SET_POS: begin
                // a target equal to the position acts as stop
                if (tv_clamped == nxt.current_position) begin
                    nxt.target_position = nxt.current_position;
                    nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
                end else begin
                    nxt.target_position = tv_clamped;
                    nxt.motion_state    = (tv_clamped > nxt.current_position) ?
                                          tbpc_pkg::MOT_OPENING : tbpc_pkg::MOT_CLOSING;
                    nxt.last_step_time  = item.now_ms;
                end
            end
            tbpc_pkg::OP_STOP: begin
                nxt.target_position = nxt.current_position;
                nxt.motion_state    = tbpc_pkg::MOT_STOPPED;
            end
            tbpc_pkg::OP_LOAD: begin
                nxt.current_position = tv_clamped;
                nxt.target_position  = tv_clamped;
                nxt.motion_state     = tbpc_pkg::MOT_STOPPED;
            end
        endcase
    end

    assign state_nxt               = nxt;
    assign result.relay_open       = (nxt.motion_state == tbpc_pkg::MOT_OPENING);
    assign result.relay_close      = (nxt.motion_state == tbpc_pkg::MOT_CLOSING);
    assign result.motion           = nxt.motion_state;
    assign result.position         = nxt.current_position;
    assign result.position_changed = changed;

endmodule

[hdl/timed_blind_position_controller_core.sv]
// a beat accepted on s_ is held in the input register, then in the result register, and is offered on m_
// throughput: one beat per cycle while the result is taken, set by the combinational state update between the registers
// a stalled result lets one more beat into the input register, then s_ready drops until m_ready
// reset (aresetn low, synchronous) stops the blind at position 0, target 0, timer 0
// reset restores step time 1000 ms, both buttons enabled, no swap; both channels empty
module timed_blind_position_controller_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbpc_pkg::item_t     s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tbpc_pkg::result_t   m_data
);

`include "timed_blind_position_controller_core_macros.svh"

    tbpc_pkg::cfg_t    cfg;
    tbpc_pkg::item_t   in_data_reg;
    logic              in_valid_reg;
    tbpc_pkg::state_t  state_reg;
    tbpc_pkg::state_t  state_next;
    tbpc_pkg::result_t out_data_reg;
    tbpc_pkg::result_t out_data_next;
    logic              out_valid_reg;
    logic              advance;

    tbpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tbpc_step u_step (
        .cfg       (cfg),
        .state_cur (state_reg),
        .item      (in_data_reg),
        .state_nxt (state_next),
        .result    (out_data_next)
    );

    // held beat moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= tbpc_pkg::STATE_RESET;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `TBPC_ASSERT_RUN(a_no_step_outside_control, aclk, aresetn, advance && in_data_reg.operation != tbpc_pkg::OP_CONTROL |=> !out_data_reg.position_changed, "position step on a non-control beat")
    `TBPC_ASSERT_RUN(a_load_stops, aclk, aresetn, advance && in_data_reg.operation == tbpc_pkg::OP_LOAD |=> out_data_reg.motion == tbpc_pkg::MOT_STOPPED && !out_data_reg.relay_open && !out_data_reg.relay_close, "load position left the blind moving")
    `TBPC_ASSERT_RUN(a_state_held_when_idle, aclk, aresetn, !advance |=> $stable(state_reg), "state changed without a beat")
    `TBPC_ASSERT_RUN(a_relays_match_motion, aclk, aresetn, m_valid |-> (m_data.relay_open == (m_data.motion == tbpc_pkg::MOT_OPENING)) && (m_data.relay_close == (m_data.motion == tbpc_pkg::MOT_CLOSING)), "relay drive disagrees with motion")
    `TBPC_ASSERT_ALWAYS(a_position_in_range, aclk, !aresetn || (state_reg.current_position <= tbpc_pkg::MAX_POS && state_reg.target_position <= tbpc_pkg::MAX_POS), "position beyond maximum")

endmodule
